[hw/rtl/slot_allocator_with_timeout_defines.svh]
// Assertion macros for the checker file of the slot allocator.
`ifndef SLOT_ALLOCATOR_WITH_TIMEOUT_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_TIMEOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`endif

[hw/rtl/sat_pkg.sv]
`default_nettype none

package sat_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned IN_IDX_W   = 4;
    // Internal slot index width, wide enough for the largest pool (1024).
    localparam int unsigned SLOT_IDX_W = 10;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300;
    localparam logic              REG_TIMEOUT   = 1'b0;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_RELEASE  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IN_IDX_W-1:0] slot_index;
        logic [TIME_W-1:0]   now_seconds;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [IN_IDX_W-1:0] slot;
        logic                reclaimed;
    } t_rsp;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic                  valid;
        logic                  has_free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic                  has_stale;
        logic [SLOT_IDX_W-1:0] stale_idx;
    } t_scan;

    // Write broadcast from the controller to all cells.
    typedef struct packed {
        logic                  en;
        logic                  busy;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TIME_W-1:0]     stamp;
    } t_cell_wr;

endpackage

`default_nettype wire

[hw/rtl/sat_cell.sv]
`default_nettype none

module sat_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [sat_pkg::TIME_W-1:0]  i_now,
    input  wire logic [sat_pkg::TIME_W-1:0]  i_timeout,
    input  wire sat_pkg::t_cell_wr           i_wr,
    input  wire sat_pkg::t_scan              i_scan,
    output sat_pkg::t_scan                   o_scan
);

    localparam logic [sat_pkg::SLOT_IDX_W-1:0] MY_IDX = sat_pkg::SLOT_IDX_W'(IDX);

    logic                       r_busy;
    logic [sat_pkg::TIME_W-1:0] r_time;
    logic                       r_valid;
    sat_pkg::t_scan             r_scan;
    sat_pkg::t_scan             n_scan;
    logic                       w_hit;
    logic [sat_pkg::TIME_W-1:0] w_age;
    logic                       w_stale;

    assign w_hit   = i_wr.en && (i_wr.idx == MY_IDX);
    assign w_age   = i_now - r_time;
    assign w_stale = r_busy && (w_age > i_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_hit) begin
            r_busy <= i_wr.busy;
        end
    end

    // Stamp only when the slot turns or stays busy.
    always_ff @(posedge i_clk) begin
        if (w_hit && i_wr.busy) begin
            r_time <= i_wr.stamp;
        end
    end

    // Keep the lowest free and lowest stale index seen so far.
    always_comb begin
        n_scan           = i_scan;
        n_scan.has_free  = i_scan.has_free || !r_busy;
        n_scan.free_idx  = i_scan.has_free ? i_scan.free_idx : MY_IDX;
        n_scan.has_stale = i_scan.has_stale || w_stale;
        n_scan.stale_idx = i_scan.has_stale ? i_scan.stale_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    always_comb begin
        o_scan       = r_scan;
        o_scan.valid = r_valid;
    end

endmodule

`default_nettype wire

[hw/rtl/slot_allocator_with_timeout.sv]
`default_nettype none

// Slot allocator with timeout reclaim.
//
// Request channel: drive i_req and raise start; the item is taken at the
// clock edge where start is high and busy is low. op selects allocate or
// release. Allocate grants the lowest free slot, else reclaims the lowest
// busy slot whose age (now minus last grant, mod 2^32) exceeds the timeout,
// else fails. Release clears the named slot, if in range; result all zero.
// Result channel: o_result is shown for exactly one cycle with
// o_result_valid high. The receiver cannot stall, so no result is held.
// Timing: a release result appears in the cycle after the item is taken,
// and the next item may follow at once. An allocate sends a scan token
// through the row of SLOT_COUNT cells, one cell per cycle; its result is
// registered after the token leaves the last cell (r_go, one register per
// cell, then the result register). busy is high meanwhile and drops with
// the result, so no next item is taken until an allocate's result shows.
// The scan length, one register per cell, sets the allocate rate.
// Config: APB register 0 (address 0) holds timeout_seconds, reset 300.
// Reset: all slots free, no scan in flight, no result pending.
module slot_allocator_with_timeout #(
    parameter int unsigned SLOT_COUNT = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sat_pkg::t_req i_req,
    output logic               o_result_valid,
    output sat_pkg::t_rsp      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                     r_state;
    logic                       r_go;
    logic [sat_pkg::TIME_W-1:0] r_now;
    logic [sat_pkg::TIME_W-1:0] r_timeout;
    logic                       r_rsp_valid;
    sat_pkg::t_rsp              r_rsp;
    sat_pkg::t_rsp              n_rsp;
    sat_pkg::t_cell_wr          w_wr;
    sat_pkg::t_scan             w_scan [SLOT_COUNT+1];
    sat_pkg::t_scan             w_last;
    logic                       w_accept;
    logic                       w_rel_ok;
    logic                       w_done;

    // Config port: always ready, one register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sat_pkg::REG_TIMEOUT) ? r_timeout : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= sat_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == sat_pkg::REG_TIMEOUT)) begin
            r_timeout <= pwdata;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && (r_state == ST_IDLE);
    // Drop releases that name a slot outside the pool.
    assign w_rel_ok = 32'(i_req.slot_index) < 32'(SLOT_COUNT);

    // Inject a fresh token at the head of the row.
    always_comb begin
        w_scan[0]           = '0;
        w_scan[0].valid     = r_go;
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        sat_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_now     (r_now),
            .i_timeout (r_timeout),
            .i_wr      (w_wr),
            .i_scan    (w_scan[g]),
            .o_scan    (w_scan[g+1])
        );
    end

    assign w_last = w_scan[SLOT_COUNT];
    assign w_done = (r_state == ST_SCAN) && w_last.valid;

    // Cell writes: release in the accept cycle, grant when the token exits.
    always_comb begin
        w_wr       = '0;
        w_wr.stamp = r_now;
        n_rsp      = '0;
        if (w_accept && (i_req.op == sat_pkg::OP_RELEASE) && w_rel_ok) begin
            w_wr.en   = 1'b1;
            w_wr.busy = 1'b0;
            w_wr.idx  = sat_pkg::SLOT_IDX_W'(i_req.slot_index);
        end else if (w_done && w_last.has_free) begin
            w_wr.en       = 1'b1;
            w_wr.busy     = 1'b1;
            w_wr.idx      = w_last.free_idx;
            n_rsp.granted = 1'b1;
            n_rsp.slot    = sat_pkg::IN_IDX_W'(w_last.free_idx);
        end else if (w_done && w_last.has_stale) begin
            w_wr.en         = 1'b1;
            w_wr.busy       = 1'b1;
            w_wr.idx        = w_last.stale_idx;
            n_rsp.granted   = 1'b1;
            n_rsp.slot      = sat_pkg::IN_IDX_W'(w_last.stale_idx);
            n_rsp.reclaimed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_go        <= 1'b0;
            r_rsp_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_now <= i_req.now_seconds;
                        if (i_req.op == sat_pkg::OP_RELEASE) begin
                            r_rsp_valid <= 1'b1;
                            r_rsp       <= n_rsp;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Hold until the token leaves the last cell, then report.
                    if (w_last.valid) begin
                        r_rsp_valid <= 1'b1;
                        r_rsp       <= n_rsp;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_rsp_valid;
    assign o_result       = r_rsp;

endmodule

`default_nettype wire

[hw/rtl/sat_checker.sv]
`default_nettype none

`include "slot_allocator_with_timeout_defines.svh"

module sat_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_result_valid,
    input wire sat_pkg::t_rsp o_result
);

    // A taken item shows up as either a scan in progress or a result.
    `SAT_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_result_valid)

    // A result follows an accept or ends a scan.
    `SAT_ASSERT_NOW(a_result_cause, i_clk, i_rst_n, o_result_valid, $past(start && !busy) || $past(busy))

    // A failed or release result carries no slot.
    `SAT_ASSERT_NOW(a_no_grant_zero, i_clk, i_rst_n, o_result_valid && !o_result.granted, (o_result.slot == 4'd0) && !o_result.reclaimed)

    // A reclaim is always a grant.
    `SAT_ASSERT_NOW(a_reclaim_grant, i_clk, i_rst_n, o_result_valid && o_result.reclaimed, o_result.granted)

endmodule

bind slot_allocator_with_timeout sat_checker u_sat_checker (.*);

`default_nettype wire
